FILE: rtl/running_median_insert_unit_macros.svh
// assertion helpers for the running median insert unit
`ifndef RUNNING_MEDIAN_INSERT_UNIT_MACROS_SVH
`define RUNNING_MEDIAN_INSERT_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RMI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define RMI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: rtl/rmi_pkg.sv
package rmi_pkg;

  localparam int unsigned IN_W     = 32;
  localparam int unsigned HELD_W   = 9;
  localparam int unsigned GRP_SIZE = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_MGRP,
    ST_MOUT
  } st_e;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic tok_mv;
  } cell_ctl_t;

endpackage

FILE: rtl/rmi_cell.sv
module rmi_cell
  import rmi_pkg::*;
#(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctl_t           ctl_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic                left_gt_i,
  input  logic                left_vld_i,
  input  logic                left_tok_i,
  output logic [KEY_BITS-1:0] key_o,
  output logic                gt_o,
  output logic                vld_o,
  output logic                tok_o,
  output logic                eq_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic                gt_q, gt_d;
  logic                vld_q, vld_d;
  logic                tok_q, tok_d;

  always_comb begin
    gt_d  = gt_q;
    key_d = key_q;
    vld_d = vld_q;
    tok_d = tok_q;
    if (ctl_i.cmp) begin
      gt_d = vld_q && ($signed(key_q) > $signed(new_key_i));
    end
    if (ctl_i.ins) begin
      vld_d = left_vld_i;
      if (left_gt_i) begin
        key_d = left_key_i;
      end else if (gt_q || !vld_q) begin
        key_d = new_key_i;
      end
    end
    if (ctl_i.tok_mv) begin
      tok_d = left_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q  <= 1'b0;
      vld_q <= 1'b0;
      tok_q <= 1'b0;
    end else begin
      gt_q  <= gt_d;
      vld_q <= vld_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
  assign gt_o  = gt_q;
  assign vld_o = vld_q;
  assign tok_o = tok_q;
  assign eq_o  = vld_q && (key_q == new_key_i);

endmodule

FILE: rtl/running_median_insert_unit.sv
// Running median of distinct signed keys. Pulse start_i while busy_o is low to
// insert new_key_i; the block then steps through ST_CMP, ST_UPD, ST_MGRP and
// ST_MOUT and reports the lower median of the keys held, their count and the
// duplicate and dropped flags, on done_o for exactly one cycle. That result
// cannot be held off, so capture it when done_o is high. A key goes through a
// compare of every cell against the key, a reduction of the match bits in
// groups of sixteen cells followed by the shift of the sorted cell row, and a
// two-level reduction that pulls the median cell's key out of the row. A key
// that is already held leaves the set unchanged; a new key that meets a full
// set is dropped. A new key may be started in the cycle that done_o is high.
module running_median_insert_unit
  import rmi_pkg::*;
#(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [IN_W-1:0]   new_key_i,
  output logic              done_o,
  output logic [IN_W-1:0]   median_key_o,
  output logic [HELD_W-1:0] held_count_o,
  output logic              was_duplicate_o,
  output logic              was_dropped_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned NGRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned NPAD  = NGRP * GRP_SIZE;

  st_e                 state_q, state_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [KEY_BITS-1:0] key_ext;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                dup_q, dup_d;
  logic                drop_q, drop_d;
  logic                done_q, done_d;
  logic [KEY_BITS-1:0] med_q, med_d;
  cell_ctl_t           ctl;
  logic                dup_w, full_w, ins_w;

  logic [KEY_BITS-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_gt, cell_vld, cell_tok, cell_eq;

  logic [KEY_BITS-1:0] med_pad [NPAD];
  logic [NPAD-1:0]     eq_pad;
  logic [NGRP-1:0]     grp_eq_q, grp_eq_d;
  logic [KEY_BITS-1:0] grp_med_q [NGRP];
  logic [KEY_BITS-1:0] grp_med_d [NGRP];
  logic [KEY_BITS-1:0] med_or;

  if (KEY_BITS > IN_W) begin : g_ext_wide
    assign key_ext = {{(KEY_BITS - IN_W){new_key_i[IN_W-1]}}, new_key_i};
    assign median_key_o = med_q[IN_W-1:0];
  end else if (KEY_BITS < IN_W) begin : g_ext_narrow
    assign key_ext = new_key_i[KEY_BITS-1:0];
    assign median_key_o = {{(IN_W - KEY_BITS){med_q[KEY_BITS-1]}}, med_q};
  end else begin : g_ext_same
    assign key_ext = new_key_i;
    assign median_key_o = med_q;
  end

  if (CNT_W > HELD_W) begin : g_cnt_wide
    assign held_count_o = cnt_q[HELD_W-1:0];
  end else if (CNT_W < HELD_W) begin : g_cnt_narrow
    assign held_count_o = {{(HELD_W - CNT_W){1'b0}}, cnt_q};
  end else begin : g_cnt_same
    assign held_count_o = cnt_q;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      rmi_cell #(
        .KEY_BITS(KEY_BITS)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctl_i     (ctl),
        .new_key_i (key_q),
        .left_key_i('0),
        .left_gt_i (1'b0),
        .left_vld_i(1'b1),
        .left_tok_i(cnt_q == '0),
        .key_o     (cell_key[i]),
        .gt_o      (cell_gt[i]),
        .vld_o     (cell_vld[i]),
        .tok_o     (cell_tok[i]),
        .eq_o      (cell_eq[i])
      );
    end else begin : g_body
      rmi_cell #(
        .KEY_BITS(KEY_BITS)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctl_i     (ctl),
        .new_key_i (key_q),
        .left_key_i(cell_key[i-1]),
        .left_gt_i (cell_gt[i-1]),
        .left_vld_i(cell_vld[i-1]),
        .left_tok_i(cell_tok[i-1]),
        .key_o     (cell_key[i]),
        .gt_o      (cell_gt[i]),
        .vld_o     (cell_vld[i]),
        .tok_o     (cell_tok[i]),
        .eq_o      (cell_eq[i])
      );
    end
  end

  for (genvar j = 0; j < NPAD; j++) begin : g_pad
    if (j < CAPACITY) begin : g_live
      assign med_pad[j] = cell_tok[j] ? cell_key[j] : '0;
      assign eq_pad[j]  = cell_eq[j];
    end else begin : g_dead
      assign med_pad[j] = '0;
      assign eq_pad[j]  = 1'b0;
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_eq_d[g]  = |eq_pad[g*GRP_SIZE +: GRP_SIZE];
      grp_med_d[g] = '0;
      for (int c = 0; c < GRP_SIZE; c++) begin
        grp_med_d[g] = grp_med_d[g] | med_pad[g*GRP_SIZE + c];
      end
    end
  end

  always_comb begin
    med_or = '0;
    for (int g = 0; g < NGRP; g++) begin
      med_or = med_or | grp_med_q[g];
    end
  end

  assign dup_w  = |grp_eq_q;
  assign full_w = (cnt_q == CNT_W'(CAPACITY));
  assign ins_w  = !dup_w && !full_w;

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    cnt_d      = cnt_q;
    dup_d      = dup_q;
    drop_d     = drop_q;
    med_d      = med_q;
    done_d     = 1'b0;
    ctl.cmp    = 1'b0;
    ctl.ins    = 1'b0;
    ctl.tok_mv = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          key_d   = key_ext;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        ctl.cmp = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        dup_d      = dup_w;
        drop_d     = !dup_w && full_w;
        ctl.ins    = ins_w;
        ctl.tok_mv = ins_w && !cnt_q[0];
        if (ins_w) begin
          cnt_d = cnt_q + 1'b1;
        end
        state_d = ST_MGRP;
      end
      ST_MGRP: begin
        state_d = ST_MOUT;
      end
      ST_MOUT: begin
        med_d   = med_or;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      grp_eq_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (state_q == ST_CMP) begin
        grp_eq_q <= grp_eq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    dup_q  <= dup_d;
    drop_q <= drop_d;
    med_q  <= med_d;
    if (state_q == ST_MGRP) begin
      grp_med_q <= grp_med_d;
    end
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign was_duplicate_o = dup_q;
  assign was_dropped_o   = drop_q;

endmodule

FILE: rtl/rmi_checker.sv
`include "running_median_insert_unit_macros.svh"

module rmi_checker
  import rmi_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input logic [HELD_W-1:0] held_count_o,
  input logic              was_duplicate_o,
  input logic              was_dropped_o
);

  `RMI_ASSERT_IMP(a_word_latency, start_i && !busy_o, ##5 done_o)
  `RMI_ASSERT_NXT(a_busy_after_start, start_i && !busy_o, busy_o && !done_o)
  `RMI_ASSERT_IMP(a_flags_exclusive, done_o, !(was_duplicate_o && was_dropped_o))
  `RMI_ASSERT_IMP(a_count_nonzero, done_o, held_count_o != '0)

endmodule

bind running_median_insert_unit rmi_checker u_rmi_checker (.*);
